>>> rtl/core/mrst_pkg.sv
// ----------------------------------------------------------------------------
// MIDI running-status transmit queue: shared package
// Codes for commands, message kinds and enqueue steps, default sizes, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mrst_pkg;

	localparam int RING_DEPTH_DEF = 32;
	localparam int BATCH_MAX_DEF  = 8;

	localparam logic CMD_ENQUEUE = 1'b0;
	localparam logic CMD_RUN     = 1'b1;

	localparam logic [2:0] KIND_REALTIME  = 3'd0;
	localparam logic [2:0] KIND_NO_PARAM  = 3'd1;
	localparam logic [2:0] KIND_ONE_PARAM = 3'd2;
	localparam logic [2:0] KIND_TWO_PARAM = 3'd3;

	// Enqueue steps: one ring write opportunity per step.
	localparam logic [1:0] STEP_STATUS = 2'd0;
	localparam logic [1:0] STEP_FIRST  = 2'd1;
	localparam logic [1:0] STEP_SECOND = 2'd2;

	typedef struct packed {
		logic       latch;      // capture the accepted request word
		logic       push;       // perform the enqueue step below
		logic [1:0] step;
		logic       load_enq;   // load the enqueue result word
		logic       load_empty; // load the run-on-empty result word
		logic       load_byte;  // pop one byte into the result register
		logic       byte_last;  // last flag for the popped byte
	} mrst_cmd_t;

	typedef struct packed {
		logic out_free;       // result register can take a word this cycle
		logic ring_empty;
		logic last_after_pop; // ring becomes empty after one pop
	} mrst_sts_t;

endpackage

>>> rtl/core/midi_running_status_tx_queue_top.sv
// ----------------------------------------------------------------------------
// MIDI running-status transmit queue: top level
// Queues MIDI messages as bytes with running-status compression and drains
// them in batches.
// ----------------------------------------------------------------------------
// An enqueue word is taken, then offers its status, first and second
// parameter bytes to the ring in turn (one ring write per cycle at most),
// and then loads its single result word. A run word drains one byte per
// cycle from the ring into the result register while the output is not
// stalled, up to BATCH_MAX bytes. The ring keeps RING_DEPTH - 1 bytes; a
// byte offered to a full ring is dropped and flagged in the overflow bit of
// the enqueue result. The ring needs no clearing after reset. A new request
// word is taken as soon as the last result word of the previous one sits in
// the output register, even if it has not been taken yet.
module midi_running_status_tx_queue_top import mrst_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	parameter int BATCH_MAX  = BATCH_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic       command,
	input  logic [2:0] msg_kind,
	input  logic [7:0] status_byte,
	input  logic [7:0] first_param,
	input  logic [7:0] second_param,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       last,
	output logic       overflow
);

	mrst_cmd_t cmd;
	mrst_sts_t sts;

	mrst_ctrl #(
		.BATCH_MAX(BATCH_MAX)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.command  (command),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mrst_dp #(
		.RING_DEPTH(RING_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.msg_kind    (msg_kind),
		.status_byte (status_byte),
		.first_param (first_param),
		.second_param(second_param),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.last        (last),
		.overflow    (overflow)
	);

endmodule

>>> rtl/core/mrst_ctrl.sv
// ----------------------------------------------------------------------------
// MIDI running-status transmit queue: controller
// Sequences the enqueue steps and the batched drain, and counts drained bytes.
// ----------------------------------------------------------------------------
module mrst_ctrl import mrst_pkg::*; #(
	parameter int BATCH_MAX = BATCH_MAX_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      command,
	output logic      req_stall,
	input  mrst_sts_t sts,
	output mrst_cmd_t cmd
);

	localparam int CW = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;

	typedef enum logic [1:0] {ST_IDLE, ST_ENQ, ST_ENQ_RES, ST_DRN} state_t;

	state_t        state_q;
	logic [1:0]    step_q;
	logic [CW-1:0] cnt_q;
	logic          batch_end;

	assign batch_end = (cnt_q == CW'(BATCH_MAX - 1));
	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.latch = req_valid;
			end
			ST_ENQ: begin
				cmd.push = 1'b1;
				cmd.step = step_q;
			end
			ST_ENQ_RES: begin
				cmd.load_enq = sts.out_free;
			end
			ST_DRN: begin
				cmd.load_empty = sts.out_free && sts.ring_empty;
				cmd.load_byte  = sts.out_free && !sts.ring_empty;
				cmd.byte_last  = sts.last_after_pop || batch_end;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= STEP_STATUS;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= (command == CMD_RUN) ? ST_DRN : ST_ENQ;
						step_q  <= STEP_STATUS;
						cnt_q   <= '0;
					end
				end
				ST_ENQ: begin
					if (step_q == STEP_SECOND) begin
						state_q <= ST_ENQ_RES;
					end else begin
						step_q <= step_q + 2'd1;
					end
				end
				ST_ENQ_RES: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DRN: begin
					if (sts.out_free) begin
						if (sts.ring_empty || cmd.byte_last) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/mrst_dp.sv
// ----------------------------------------------------------------------------
// MIDI running-status transmit queue: datapath
// Byte ring with its pointers, running-status register, request latch and
// the result register that faces the output channel.
// ----------------------------------------------------------------------------
module mrst_dp import mrst_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  mrst_cmd_t  cmd,
	output mrst_sts_t  sts,
	input  logic [2:0] msg_kind,
	input  logic [7:0] status_byte,
	input  logic [7:0] first_param,
	input  logic [7:0] second_param,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       last,
	output logic       overflow
);

	localparam int PW = $clog2(RING_DEPTH);

	logic [7:0]    ring_mem [RING_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q, wr_next, rd_next;
	logic [7:0]    last_status_q;
	logic [2:0]    kind_q;
	logic [7:0]    status_q, p1_q, p2_q;
	logic          ovf_q;
	logic          rsp_valid_q, byte_valid_q, last_q, overflow_q;
	logic [7:0]    out_byte_q;
	logic          push_req, push_is_status, ring_full, wr_en;
	logic [7:0]    push_data;

	assign wr_next = (wr_ptr_q == PW'(RING_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
	assign rd_next = (rd_ptr_q == PW'(RING_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
	assign ring_full = (wr_next == rd_ptr_q);

	assign sts.out_free       = !rsp_valid_q || !rsp_stall;
	assign sts.ring_empty     = (rd_ptr_q == wr_ptr_q);
	assign sts.last_after_pop = (rd_next == wr_ptr_q);

	// Pick the byte offered to the ring in the current enqueue step.
	always_comb begin
		push_req       = 1'b0;
		push_is_status = 1'b0;
		push_data      = status_q;
		case (cmd.step)
			STEP_STATUS: begin
				if (kind_q inside {KIND_REALTIME, KIND_NO_PARAM}) begin
					push_req = 1'b1;
				end else if (kind_q inside {KIND_ONE_PARAM, KIND_TWO_PARAM}) begin
					push_req       = (status_q != last_status_q);
					push_is_status = 1'b1;
				end
			end
			STEP_FIRST: begin
				push_req  = (kind_q inside {KIND_ONE_PARAM, KIND_TWO_PARAM});
				push_data = p1_q;
			end
			STEP_SECOND: begin
				push_req  = (kind_q == KIND_TWO_PARAM);
				push_data = p2_q;
			end
			default: begin
			end
		endcase
	end

	assign wr_en = cmd.push && push_req && !ring_full;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q   <= msg_kind;
			status_q <= status_byte;
			p1_q     <= first_param;
			p2_q     <= second_param;
		end
		if (wr_en) begin
			ring_mem[wr_ptr_q] <= push_data;
		end
		if (cmd.load_byte) begin
			out_byte_q <= ring_mem[rd_ptr_q];
		end else if (cmd.load_enq || cmd.load_empty) begin
			out_byte_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q      <= '0;
			rd_ptr_q      <= '0;
			last_status_q <= '0;
			ovf_q         <= 1'b0;
			rsp_valid_q   <= 1'b0;
			byte_valid_q  <= 1'b0;
			last_q        <= 1'b0;
			overflow_q    <= 1'b0;
		end else begin
			if (cmd.latch) begin
				ovf_q <= 1'b0;
			end else if (cmd.push && push_req && ring_full) begin
				ovf_q <= 1'b1;
			end
			if (wr_en) begin
				wr_ptr_q <= wr_next;
				if (push_is_status) begin
					last_status_q <= status_q;
				end
			end
			if (cmd.load_byte) begin
				rd_ptr_q <= rd_next;
			end
			if (cmd.load_enq || cmd.load_empty || cmd.load_byte) begin
				rsp_valid_q  <= 1'b1;
				byte_valid_q <= cmd.load_byte;
				last_q       <= cmd.load_byte ? cmd.byte_last : 1'b1;
				overflow_q   <= cmd.load_enq && ovf_q;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign last       = last_q;
	assign overflow   = overflow_q;

endmodule

>>> rtl/core/mrst_chk.sv
// ----------------------------------------------------------------------------
// MIDI running-status transmit queue: port checker
// Watches the top-level ports and flags result words that break the block's
// rules, and is bound to every instance of the top level.
// ----------------------------------------------------------------------------
module mrst_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_stall,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic       last,
	input logic       overflow
);

	// A word without a drained byte always closes its request.
	a_nobyte_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !byte_valid |-> last)
		else $error("result word without byte is not marked last");

	a_nobyte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !byte_valid |-> out_byte == 8'd0)
		else $error("result word without byte carries a nonzero byte");

	// Overflow belongs to enqueue results only.
	a_byte_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && byte_valid |-> !overflow)
		else $error("drained byte reports overflow");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(out_byte) && $stable(last))
		else $error("stalled result word changed");

endmodule

bind midi_running_status_tx_queue_top mrst_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.out_byte  (out_byte),
	.byte_valid(byte_valid),
	.last      (last),
	.overflow  (overflow)
);
